// File: hw/rtl/lgg_pkg.sv
// Package for the streaming Game of Life generation block.
// Holds the default sizes and the result record type; depends on nothing.
package lgg_pkg;

  localparam int DEFAULT_MAX_SIZE = 1024;
  localparam int RESET_GRID_SIZE  = 100;
  localparam int MIN_GRID_SIZE    = 3;
  localparam int CFG_WIDTH        = 11;
  localparam int COORD_WIDTH      = 10;
  localparam int QUEUE_DEPTH      = 3;
  localparam int BIRTH_COUNT      = 3;
  localparam int SURVIVE_COUNT    = 2;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] row;
    logic [COORD_WIDTH-1:0] col;
    logic                   alive;
    logic                   last;
  } result_t;

endpackage

// File: hw/rtl/life_grid_generation_stream.sv
// Streaming Game of Life (B3/S23) generation engine with two line buffers.
// Depends on lgg_pkg for sizes and the result record.
//
// Usage: cells of one square generation enter in raster order on the cell
// channel (cell_valid/cell_ready, payload cell_alive), one per transfer.
// For every interior cell the block returns one transfer on the result
// channel (result_valid/result_ready) with its row, column, next state
// and a flag on the frame's last interior cell; border cells produce no
// transfer. The result for cell (r-1, c-1) is formed in the window stage
// from cell (r, c). Throughput is one cell per cycle while the queue has
// room; the two line buffers share one memory whose read and write-back
// each take one port per cycle, and a three-entry result queue absorbs
// the pipeline. When the receiver stalls, the queue fills and cell_ready
// drops once queue and stage in flight could not hold another result.
// Reset sets the side to 100 (clamped to MAX_SIZE), empties the queue and
// starts a new frame; the line buffers need no clearing pass. Writing the
// side through cfg_we/cfg_wdata, only while idle, also starts a new frame.
module life_grid_generation_stream #(
  parameter int MAX_SIZE = lgg_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lgg_pkg::CFG_WIDTH-1:0]   cfg_wdata,
  input  logic                            cell_valid,
  output logic                            cell_ready,
  input  logic                            cell_alive,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [lgg_pkg::COORD_WIDTH-1:0] cell_row,
  output logic [lgg_pkg::COORD_WIDTH-1:0] cell_col,
  output logic                            alive_next,
  output logic                            frame_last
);

  localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int RESET_SIDE = (lgg_pkg::RESET_GRID_SIZE > MAX_SIZE) ?
                              MAX_SIZE : lgg_pkg::RESET_GRID_SIZE;
  localparam int QD = lgg_pkg::QUEUE_DEPTH;
  localparam int QW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  logic [CW-1:0] last_idx;
  logic [CW-1:0] row_counter;
  logic [CW-1:0] col_counter;
  logic [5:0]    window_columns;

  logic [1:0]    line_mem [MAX_SIZE];
  logic [1:0]    line_rdata;

  logic          s1_valid;
  logic          s1_bot;
  logic          s1_emit;
  logic          s1_last;
  logic [CW-1:0] s1_row;
  logic [CW-1:0] s1_col;

  lgg_pkg::result_t queue [QD];
  logic [QW-1:0]    q_wptr;
  logic [QW-1:0]    q_rptr;
  logic [QCW-1:0]   q_count;

  logic          cell_xfer;
  logic          q_push;
  logic          q_pop;
  logic [12:0]   cfg_ext;
  logic [12:0]   side_clamped;
  logic [2:0]    col_bits;
  logic [3:0]    neighbors;
  logic          center;
  logic [CW-1:0] row_m1;
  logic [CW-1:0] col_m1;
  lgg_pkg::result_t s1_result;

  assign cell_xfer = cell_valid && cell_ready;
  assign q_push    = s1_valid && s1_emit;
  assign q_pop     = result_valid && result_ready;
  assign cell_ready = ({1'b0, q_count} + {{QCW{1'b0}}, q_push}) <= (QCW + 1)'(QD - 1);

  always_comb begin
    cfg_ext = 13'(cfg_wdata);
    if (cfg_ext < 13'(lgg_pkg::MIN_GRID_SIZE)) begin
      side_clamped = 13'(lgg_pkg::MIN_GRID_SIZE);
    end else if (cfg_ext > 13'(MAX_SIZE)) begin
      side_clamped = 13'(MAX_SIZE);
    end else begin
      side_clamped = cfg_ext;
    end
  end

  // Input stage: raster counters and the line buffer read.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx    <= CW'(RESET_SIDE - 1);
      row_counter <= '0;
      col_counter <= '0;
      s1_valid    <= 1'b0;
    end else if (cfg_we) begin
      last_idx    <= CW'(side_clamped - 13'd1);
      row_counter <= '0;
      col_counter <= '0;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= cell_xfer;
      if (cell_xfer) begin
        if (col_counter == last_idx) begin
          col_counter <= '0;
          row_counter <= (row_counter == last_idx) ? '0 : row_counter + 1'b1;
        end else begin
          col_counter <= col_counter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_xfer) begin
      s1_bot  <= cell_alive;
      s1_row  <= row_counter;
      s1_col  <= col_counter;
      s1_emit <= (row_counter >= CW'(2)) && (col_counter >= CW'(2));
      s1_last <= (row_counter == last_idx) && (col_counter == last_idx);
    end
  end

  // Bit 1 holds the older row, bit 0 the newer row.
  always_ff @(posedge clk) begin
    if (cell_xfer) begin
      line_rdata <= line_mem[col_counter];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {line_rdata[0], s1_bot};
    end
  end

  // Window stage: neighbor count and rule.
  assign col_bits = {s1_bot, line_rdata[0], line_rdata[1]};
  assign center   = window_columns[1];
  assign neighbors = 4'(window_columns[0]) + 4'(window_columns[2]) +
                     4'(window_columns[3]) + 4'(window_columns[4]) +
                     4'(window_columns[5]) + 4'(col_bits[0]) +
                     4'(col_bits[1]) + 4'(col_bits[2]);
  assign row_m1 = s1_row - 1'b1;
  assign col_m1 = s1_col - 1'b1;

  always_comb begin
    s1_result.row   = lgg_pkg::COORD_WIDTH'(row_m1);
    s1_result.col   = lgg_pkg::COORD_WIDTH'(col_m1);
    s1_result.alive = (neighbors == 4'(lgg_pkg::BIRTH_COUNT)) ||
                      (center && (neighbors == 4'(lgg_pkg::SURVIVE_COUNT)));
    s1_result.last  = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      window_columns <= '0;
    end else if (s1_valid) begin
      window_columns <= {window_columns[2:0], col_bits};
    end
  end

  // Result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wptr <= (q_wptr == QW'(QD - 1)) ? '0 : q_wptr + 1'b1;
      end
      if (q_pop) begin
        q_rptr <= (q_rptr == QW'(QD - 1)) ? '0 : q_rptr + 1'b1;
      end
      if (q_push && !q_pop) begin
        q_count <= q_count + 1'b1;
      end else if (q_pop && !q_push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      queue[q_wptr] <= s1_result;
    end
  end

  assign result_valid = (q_count != '0);
  assign cell_row     = queue[q_rptr].row;
  assign cell_col     = queue[q_rptr].col;
  assign alive_next   = queue[q_rptr].alive;
  assign frame_last   = queue[q_rptr].last;

endmodule

// File: dv/life_grid_generation_stream_tb.sv
// Self-checking testbench for life_grid_generation_stream: drives grids of random and
// hand-built cells under random backpressure and checks every interior next state.
// Depends on lgg_pkg and the life_grid_generation_stream RTL.
`timescale 1ns / 100ps

module life_grid_generation_stream_tb;
  import lgg_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_CELLS   = 150;
  localparam int MAX_SIDE       = DEFAULT_MAX_SIZE;
  localparam int REPORT_CAP     = 30;

  localparam logic [8:0] BIRTH_FRAME    = 9'b010000101;
  localparam logic [8:0] SURVIVAL_FRAME = 9'b100010001;
  localparam logic [8:0] CROWDED_FRAME  = 9'b111111111;

  class next_generation_tracker;
    logic [CFG_WIDTH-1:0] size_reg;
    int unsigned          row_pos;
    int unsigned          col_pos;
    bit [MAX_SIDE-1:0]    upper_line;
    bit [MAX_SIDE-1:0]    lower_line;
    bit [5:0]             window;
    result_t              due_cells[$];
    int unsigned          errors;

    function new();
      size_reg = CFG_WIDTH'(RESET_GRID_SIZE);
      row_pos = 0;
      col_pos = 0;
      window = '0;
      upper_line = '0;
      lower_line = '0;
      errors = 0;
    endfunction

    function int unsigned side();
      int unsigned n;
      n = size_reg;
      if (n < MIN_GRID_SIZE) n = MIN_GRID_SIZE;
      if (n > MAX_SIDE) n = MAX_SIDE;
      return n;
    endfunction

    function void set_size(logic [CFG_WIDTH-1:0] value);
      size_reg = value;
      row_pos = 0;
      col_pos = 0;
      window = '0;
    endfunction

    function int unsigned due_count();
      return due_cells.size();
    endfunction

    // Window bits 2..0 are column c-1 (bottom, middle, top), bits 5..3 column c-2.
    function void take_cell(bit alive);
      int unsigned n;
      int unsigned live;
      bit [2:0]    column;
      bit          centre;
      result_t     next_cell;
      n = side();
      column = {alive, lower_line[col_pos], upper_line[col_pos]};
      if (row_pos >= 2 && col_pos >= 2) begin
        centre = window[1];
        live = $countones(column) + $countones(window) - centre;
        next_cell.row = COORD_WIDTH'(row_pos - 1);
        next_cell.col = COORD_WIDTH'(col_pos - 1);
        next_cell.alive = (live == BIRTH_COUNT) || (centre && live == SURVIVE_COUNT);
        next_cell.last = (row_pos == n - 1) && (col_pos == n - 1);
        due_cells.push_back(next_cell);
      end
      window = {window[2:0], column};
      upper_line[col_pos] = lower_line[col_pos];
      lower_line[col_pos] = alive;
      col_pos++;
      if (col_pos >= n) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= n) row_pos = 0;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_cell_result(result_t got);
      result_t want;
      if (due_cells.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result with nothing due, expected none, actual row %0d col %0d",
                   $time, got.row, got.col);
        return;
      end
      want = due_cells.pop_front();
      compare_field("cell_row", want.row, got.row);
      compare_field("cell_col", want.col, got.col);
      compare_field("alive_next", want.alive, got.alive);
      compare_field("frame_last", want.last, got.last);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_WIDTH-1:0]   cfg_wdata;
  logic                   cell_valid;
  logic                   cell_ready;
  logic                   cell_alive;
  logic                   result_valid;
  logic                   result_ready;
  logic [COORD_WIDTH-1:0] cell_row;
  logic [COORD_WIDTH-1:0] cell_col;
  logic                   alive_next;
  logic                   frame_last;

  next_generation_tracker tracker = new();
  bit                     tx_steady;
  bit                     rx_steady;
  int unsigned            ready_hold;
  int unsigned            quiet_cycles;

  life_grid_generation_stream DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_alive   (cell_alive),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .alive_next   (alive_next),
    .frame_last   (frame_last)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 5))
      0: return 5;
      1: return 25;
      2: return 40;
      3: return 50;
      4: return 75;
      default: return 95;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
      result_ready <= 1'b0;
      ready_hold <= pick_gap(1'b0) + 1;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cell_valid && cell_ready) tracker.take_cell(cell_alive);
      if (result_valid && result_ready)
        tracker.check_cell_result('{row: cell_row, col: cell_col, alive: alive_next,
                                    last: frame_last});
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (cell_valid && cell_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("life_grid_generation_stream_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cell(bit alive);
    int unsigned gap;
    cell_valid <= 1'b1;
    cell_alive <= alive;
    do @(posedge clk); while (!cell_ready);
    gap = pick_gap(tx_steady);
    if ($urandom_range(0, 79) == 0) begin
      cell_valid <= 1'b0;
      do @(posedge clk); while (tracker.due_count() != 0);
    end else if (gap != 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cells(int unsigned count, int unsigned live_pct);
    for (int unsigned i = 0; i < count; i++) send_cell($urandom_range(0, 99) < live_pct);
    cell_valid <= 1'b0;
  endtask

  task automatic send_small_frame(logic [8:0] cells);
    for (int i = 0; i < 9; i++) send_cell(cells[i]);
    cell_valid <= 1'b0;
  endtask

  task automatic drain_results();
    do @(posedge clk); while (tracker.due_count() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_WIDTH-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_size(value);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned                random_cells;
    int unsigned                phase;
    int unsigned                side;
    int unsigned                count;
    logic [CFG_WIDTH-1:0]       value;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cell_valid = 1'b0;
    cell_alive = 1'b0;
    result_ready = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The first cells, two rows and part of a third, run at the reset side.
    send_cells(2 * RESET_GRID_SIZE + 12, 50);

    write_size(CFG_WIDTH'(MIN_GRID_SIZE));
    send_small_frame(BIRTH_FRAME);
    send_small_frame(SURVIVAL_FRAME);
    send_small_frame(CROWDED_FRAME);

    random_cells = 0;
    phase = 0;
    while (random_cells < RANDOM_CELLS || phase < 9) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      case (phase)
        1: value = '0;
        2: value = '1;
        4: value = CFG_WIDTH'(MIN_GRID_SIZE);
        5: value = CFG_WIDTH'(MAX_SIDE);
        8: value = CFG_WIDTH'(MAX_SIDE + 1);
        default: begin
          case ($urandom_range(0, 9))
            0: value = CFG_WIDTH'($urandom_range(0, MIN_GRID_SIZE - 1));
            1: value = CFG_WIDTH'(MIN_GRID_SIZE);
            7: value = CFG_WIDTH'($urandom_range(13, 20));
            default: value = CFG_WIDTH'($urandom_range(4, 8));
          endcase
        end
      endcase
      write_size(value);
      side = tracker.side();
      if (side >= 64) begin
        count = $urandom_range(3, 8);
      end else if (side > 12) begin
        count = $urandom_range(2 * side + 3, 3 * side);
      end else begin
        count = side * side;
        if ($urandom_range(0, 1) == 1) count += $urandom_range(1, side * side - 1);
      end
      random_cells += count;
      send_cells(count, pick_density());
      phase++;
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();
    if (tracker.errors == 0 && tracker.due_count() == 0) begin
      $display("life_grid_generation_stream_tb: clean");
    end else begin
      $display("life_grid_generation_stream_tb: errors");
    end
    $finish;
  end

endmodule
